// File: hw/rtl/tss_pkg.sv
// Shared types, codes and constants of the thread slot scheduler.
package tss_pkg;

  localparam int SLOTS_DEF = 32;
  localparam int TID_W     = 16;
  localparam int TIME_W    = 32;
  localparam int QUANT_W   = 16;
  localparam logic [QUANT_W-1:0] QUANTUM_RST = 16'd200;

  typedef enum logic [2:0] {
    ST_FREE    = 3'd0,
    ST_ACTIVE  = 3'd1,
    ST_DELETED = 3'd2,
    ST_SUSP    = 3'd3,
    ST_SLEEP   = 3'd4
  } slot_status_e;

  localparam logic [3:0] MODE_INIT    = 4'd0;
  localparam logic [3:0] MODE_CREATE  = 4'd1;
  localparam logic [3:0] MODE_EXIT    = 4'd2;
  localparam logic [3:0] MODE_YIELD   = 4'd3;
  localparam logic [3:0] MODE_SUSPEND = 4'd4;
  localparam logic [3:0] MODE_RESUME  = 4'd5;
  localparam logic [3:0] MODE_KILL    = 4'd6;
  localparam logic [3:0] MODE_SLEEP   = 4'd7;
  localparam logic [3:0] MODE_LIST    = 4'd8;

  localparam logic [1:0] OUT_OK      = 2'd0;
  localparam logic [1:0] OUT_REFUSED = 2'd1;
  localparam logic [1:0] OUT_SUSP    = 2'd2;
  localparam logic [1:0] OUT_NONE    = 2'd3;

  typedef struct packed {
    slot_status_e      status;
    logic [TID_W-1:0]  tid;
    logic [TIME_W-1:0] wake;
    logic [TIME_W-1:0] qstart;
  } slot_rec_t;

  typedef struct packed {
    logic status;
    logic tid;
    logic wake;
    logic qstart;
  } slot_mask_t;

  typedef struct packed {
    logic       en;
    slot_mask_t mask;
    slot_rec_t  rec;
  } slot_wr_t;

  typedef struct packed {
    logic [3:0]        mode;
    logic [15:0]       thread_id;
    logic [15:0]       sleep_ms;
    logic [TIME_W-1:0] now_ms;
  } tss_in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [15:0] result_tid;
    logic [4:0]  running_slot;
    logic [15:0] running_tid;
    logic        switched;
    logic [15:0] wait_ms;
    logic [5:0]  suspended_count;
    logic        last;
  } tss_out_t;

endpackage

// File: hw/rtl/tss_slot_mem.sv
// Slot table memory: one read port with registered data, one field-masked write port.
module tss_slot_mem #(
  parameter int SLOTS  = tss_pkg::SLOTS_DEF,
  parameter int ADDR_W = $clog2(SLOTS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ADDR_W-1:0]   rd_addr_i,
  output tss_pkg::slot_rec_t  rd_rec_o,
  input  logic [ADDR_W-1:0]   wr_addr_i,
  input  tss_pkg::slot_wr_t   wr_i
);

  logic [SLOTS-1:0]   vld_q;
  tss_pkg::slot_rec_t mem_q [SLOTS];
  tss_pkg::slot_rec_t rd_q;

  // an entry never written reads as free with all fields zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      if (wr_i.mask.status || !vld_q[wr_addr_i]) begin
        mem_q[wr_addr_i].status <= wr_i.mask.status ? wr_i.rec.status : tss_pkg::ST_FREE;
      end
      if (wr_i.mask.tid || !vld_q[wr_addr_i]) begin
        mem_q[wr_addr_i].tid <= wr_i.mask.tid ? wr_i.rec.tid : '0;
      end
      if (wr_i.mask.wake || !vld_q[wr_addr_i]) begin
        mem_q[wr_addr_i].wake <= wr_i.mask.wake ? wr_i.rec.wake : '0;
      end
      if (wr_i.mask.qstart || !vld_q[wr_addr_i]) begin
        mem_q[wr_addr_i].qstart <= wr_i.mask.qstart ? wr_i.rec.qstart : '0;
      end
    end
    rd_q <= vld_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
  end

  assign rd_rec_o = rd_q;

endmodule

// File: hw/rtl/thread_slot_scheduler.sv
// Top level of the thread slot scheduler: request sequencer around the slot table.
//
// A request is taken when start_i is high and busy_o low. Init, a yield inside
// its quantum and an unknown mode answer in the next cycle. Every other request
// walks the slot table one entry a cycle through the memory's single read port,
// so its cost is set by that walk: create, resume, kill and a schedule that
// finds a runnable slot end within one pass; a schedule that falls back to
// the earliest sleeper takes a second pass; list counts in one pass and, if
// any thread is suspended, reports in a second with one result beat per
// suspended thread. Each result beat is shown for one cycle on result_o with
// result_valid_o high and must be taken then. The quantum register may be
// written at any time through the cfg channel.
module thread_slot_scheduler #(
  parameter int SLOTS = tss_pkg::SLOTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  tss_pkg::tss_in_t           item_i,
  output logic                       result_valid_o,
  output tss_pkg::tss_out_t          result_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tss_pkg::QUANT_W-1:0] cfg_data_i
);

  localparam int ADDR_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int TID_W  = tss_pkg::TID_W;
  localparam int TIME_W = tss_pkg::TIME_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_BEST = 7'b0000100,
    S_FIN  = 7'b0001000,
    S_FIND = 7'b0010000,
    S_CNT  = 7'b0100000,
    S_LIST = 7'b1000000
  } state_e;

  state_e                   state_q, state_d;
  logic [ADDR_W-1:0]        cur_q, cur_d;
  logic [TID_W-1:0]         cur_tid_q, cur_tid_d;
  logic [TIME_W-1:0]        cur_qs_q, cur_qs_d;
  logic [TID_W-1:0]         next_tid_q, next_tid_d;
  logic [15:0]              quantum_q;
  tss_pkg::tss_in_t         item_q, item_d;
  logic [ADDR_W:0]          iss_q, iss_d;
  logic                     rd_pend_q, rd_pend_d;
  logic                     rd_last_q, rd_last_d;
  logic [ADDR_W-1:0]        rd_pos_q, rd_pos_d;
  logic                     sleepers_q, sleepers_d;
  logic                     susp_q, susp_d;
  logic                     best_found_q, best_found_d;
  logic [ADDR_W-1:0]        best_pos_q, best_pos_d;
  logic [TIME_W-1:0]        best_wake_q, best_wake_d;
  logic [TID_W-1:0]         best_tid_q, best_tid_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [CNT_W-1:0]         k_q, k_d;
  logic                     res_vld_q, res_vld_d;
  tss_pkg::tss_out_t        res_q, res_d;

  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  tss_pkg::slot_wr_t        wr;
  tss_pkg::slot_rec_t       rec;

  logic [ADDR_W+1:0]        rr_sum;
  logic [ADDR_W+1:0]        rr_pos;
  logic [TIME_W:0]          wake_sum;
  logic [TIME_W-1:0]        wake_sat;
  logic [TIME_W-1:0]        best_dly;
  logic [TIME_W-1:0]        best_start;
  logic [15:0]              best_wait;
  logic                     best_later;
  logic [CNT_W-1:0]         cnt_nx;
  logic                     take;
  logic                     accept;

  tss_slot_mem #(
    .SLOTS  (SLOTS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_rec_o  (rec),
    .wr_addr_i (wr_addr),
    .wr_i      (wr)
  );

  function automatic tss_pkg::tss_out_t mk_res(
    input logic [1:0]  outcome,
    input logic [15:0] rtid,
    input logic [4:0]  rslot,
    input logic [15:0] run_tid,
    input logic        sw,
    input logic [15:0] wait_ms,
    input logic [5:0]  cnt,
    input logic        last
  );
    tss_pkg::tss_out_t r;
    r.outcome         = outcome;
    r.result_tid      = rtid;
    r.running_slot    = rslot;
    r.running_tid     = run_tid;
    r.switched        = sw;
    r.wait_ms         = wait_ms;
    r.suspended_count = cnt;
    r.last            = last;
    return r;
  endfunction

  assign busy_o         = (state_q != S_IDLE);
  assign accept         = start_i && (state_q == S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // round robin position: walk offset past the slot after the current one, wrapping at SLOTS
  assign rr_sum = (ADDR_W+2)'(cur_q) + (ADDR_W+2)'(iss_q) + (ADDR_W+2)'(1);
  assign rr_pos = (rr_sum >= (ADDR_W+2)'(SLOTS)) ? rr_sum - (ADDR_W+2)'(SLOTS) : rr_sum;

  always_comb begin
    if (iss_q >= (ADDR_W+1)'(SLOTS)) begin
      rd_addr = '0;
    end else if (state_q == S_SCAN) begin
      rd_addr = rr_pos[ADDR_W-1:0];
    end else begin
      rd_addr = iss_q[ADDR_W-1:0];
    end
  end

  assign wake_sum = (TIME_W+1)'(item_i.now_ms) + (TIME_W+1)'(item_i.sleep_ms);
  assign wake_sat = wake_sum[TIME_W] ? '1 : wake_sum[TIME_W-1:0];

  assign best_later = (best_wake_q > item_q.now_ms);
  assign best_dly   = best_later ? best_wake_q - item_q.now_ms : '0;
  assign best_wait  = (best_dly > TIME_W'(16'hFFFF)) ? 16'hFFFF : best_dly[15:0];
  assign best_start = best_later ? best_wake_q : item_q.now_ms;

  assign cnt_nx = cnt_q + ((rec.status == tss_pkg::ST_SUSP) ? CNT_W'(1) : CNT_W'(0));

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    cur_tid_d    = cur_tid_q;
    cur_qs_d     = cur_qs_q;
    next_tid_d   = next_tid_q;
    item_d       = item_q;
    iss_d        = iss_q;
    rd_pend_d    = 1'b0;
    rd_last_d    = rd_last_q;
    rd_pos_d     = rd_pos_q;
    sleepers_d   = sleepers_q;
    susp_d       = susp_q;
    best_found_d = best_found_q;
    best_pos_d   = best_pos_q;
    best_wake_d  = best_wake_q;
    best_tid_d   = best_tid_q;
    cnt_d        = cnt_q;
    k_d          = k_q;
    res_vld_d    = 1'b0;
    res_d        = res_q;
    wr           = '0;
    wr_addr      = '0;
    take         = 1'b0;

    // issue one table read a cycle during any walk
    if (state_q != S_IDLE && state_q != S_FIN && iss_q < (ADDR_W+1)'(SLOTS)) begin
      rd_pend_d = 1'b1;
      rd_pos_d  = rd_addr;
      rd_last_d = (iss_q == (ADDR_W+1)'(SLOTS - 1));
      iss_d     = iss_q + (ADDR_W+1)'(1);
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d       = item_i;
          iss_d        = '0;
          sleepers_d   = 1'b0;
          susp_d       = 1'b0;
          best_found_d = 1'b0;
          cnt_d        = '0;
          k_d          = '0;
          case (item_i.mode)
            tss_pkg::MODE_INIT: begin
              next_tid_d      = next_tid_q + TID_W'(1);
              wr.en           = 1'b1;
              wr.mask         = '1;
              wr.rec.status   = tss_pkg::ST_ACTIVE;
              wr.rec.tid      = next_tid_q;
              wr.rec.wake     = '0;
              wr.rec.qstart   = item_i.now_ms;
              wr_addr         = '0;
              if (cur_q == '0) begin
                cur_tid_d = next_tid_q;
                cur_qs_d  = item_i.now_ms;
              end
              res_vld_d = 1'b1;
              res_d = mk_res(tss_pkg::OUT_OK, next_tid_q, 5'(cur_q),
                             (cur_q == '0) ? next_tid_q : cur_tid_q, 1'b0, '0, '0, 1'b1);
            end
            tss_pkg::MODE_CREATE: begin
              state_d = S_SCAN;
            end
            tss_pkg::MODE_EXIT: begin
              wr.en          = 1'b1;
              wr.mask.status = 1'b1;
              wr.rec.status  = tss_pkg::ST_DELETED;
              wr_addr        = cur_q;
              state_d        = S_SCAN;
            end
            tss_pkg::MODE_YIELD: begin
              if (item_i.now_ms < cur_qs_q ||
                  (item_i.now_ms - cur_qs_q) < TIME_W'(quantum_q)) begin
                res_vld_d = 1'b1;
                res_d = mk_res(tss_pkg::OUT_OK, '0, 5'(cur_q), cur_tid_q,
                               1'b0, '0, '0, 1'b1);
              end else begin
                state_d = S_SCAN;
              end
            end
            tss_pkg::MODE_SUSPEND: begin
              wr.en          = 1'b1;
              wr.mask.status = 1'b1;
              wr.rec.status  = tss_pkg::ST_SUSP;
              wr_addr        = cur_q;
              state_d        = S_SCAN;
            end
            tss_pkg::MODE_SLEEP: begin
              wr.en          = 1'b1;
              wr.mask.status = 1'b1;
              wr.mask.wake   = 1'b1;
              wr.rec.status  = tss_pkg::ST_SLEEP;
              wr.rec.wake    = wake_sat;
              wr_addr        = cur_q;
              state_d        = S_SCAN;
            end
            tss_pkg::MODE_RESUME, tss_pkg::MODE_KILL: begin
              state_d = S_FIND;
            end
            tss_pkg::MODE_LIST: begin
              state_d = S_CNT;
            end
            default: begin
              res_vld_d = 1'b1;
              res_d = mk_res(tss_pkg::OUT_REFUSED, '0, 5'(cur_q), cur_tid_q,
                             1'b0, '0, '0, 1'b1);
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_pend_q) begin
          if (item_q.mode == tss_pkg::MODE_CREATE) begin
            if (rec.status inside {tss_pkg::ST_FREE, tss_pkg::ST_DELETED}) begin
              next_tid_d    = next_tid_q + TID_W'(1);
              wr.en         = 1'b1;
              wr.mask       = '1;
              wr.rec.status = tss_pkg::ST_ACTIVE;
              wr.rec.tid    = next_tid_q;
              wr.rec.wake   = '0;
              wr.rec.qstart = '0;
              wr_addr       = rd_pos_q;
              if (rd_pos_q == cur_q) begin
                cur_tid_d = next_tid_q;
                cur_qs_d  = '0;
              end
              res_vld_d = 1'b1;
              res_d = mk_res(tss_pkg::OUT_OK, next_tid_q, 5'(cur_q),
                             (rd_pos_q == cur_q) ? next_tid_q : cur_tid_q,
                             1'b0, '0, '0, 1'b1);
              state_d = S_IDLE;
            end else if (rd_last_q) begin
              res_vld_d = 1'b1;
              res_d = mk_res(tss_pkg::OUT_REFUSED, '0, 5'(cur_q), cur_tid_q,
                             1'b0, '0, '0, 1'b1);
              state_d = S_IDLE;
            end
          end else begin
            case (rec.status)
              tss_pkg::ST_DELETED: begin
                wr.en          = 1'b1;
                wr.mask.status = 1'b1;
                wr.rec.status  = tss_pkg::ST_FREE;
                wr_addr        = rd_pos_q;
              end
              tss_pkg::ST_SUSP: susp_d = 1'b1;
              tss_pkg::ST_SLEEP: begin
                if (item_q.now_ms >= rec.wake) begin
                  take = 1'b1;
                end else begin
                  sleepers_d = 1'b1;
                end
              end
              tss_pkg::ST_ACTIVE: take = 1'b1;
              default: ;
            endcase
            if (take) begin
              wr.en          = 1'b1;
              wr.mask.status = 1'b1;
              wr.mask.qstart = 1'b1;
              wr.rec.status  = tss_pkg::ST_ACTIVE;
              wr.rec.qstart  = item_q.now_ms;
              wr_addr        = rd_pos_q;
              cur_d          = rd_pos_q;
              cur_tid_d      = rec.tid;
              cur_qs_d       = item_q.now_ms;
              res_vld_d      = 1'b1;
              res_d = mk_res(tss_pkg::OUT_OK, '0, 5'(rd_pos_q), rec.tid,
                             rd_pos_q != cur_q, '0, '0, 1'b1);
              state_d = S_IDLE;
            end else if (rd_last_q) begin
              if (sleepers_d) begin
                state_d = S_BEST;
              end else begin
                res_vld_d = 1'b1;
                res_d = mk_res(susp_d ? tss_pkg::OUT_SUSP : tss_pkg::OUT_NONE, '0, '0, '0,
                               1'b0, '0, '0, 1'b1);
                state_d = S_IDLE;
              end
            end
          end
        end
        if (state_d != S_SCAN) begin
          iss_d     = '0;
          rd_pend_d = 1'b0;
        end
      end

      S_BEST: begin
        if (rd_pend_q) begin
          if (rec.status == tss_pkg::ST_SLEEP && (!best_found_q || rec.wake < best_wake_q)) begin
            best_found_d = 1'b1;
            best_pos_d   = rd_pos_q;
            best_wake_d  = rec.wake;
            best_tid_d   = rec.tid;
          end
          if (rd_last_q) begin
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        wr.en          = 1'b1;
        wr.mask.status = 1'b1;
        wr.mask.qstart = 1'b1;
        wr.rec.status  = tss_pkg::ST_ACTIVE;
        wr.rec.qstart  = best_start;
        wr_addr        = best_pos_q;
        cur_d          = best_pos_q;
        cur_tid_d      = best_tid_q;
        cur_qs_d       = best_start;
        res_vld_d      = 1'b1;
        res_d = mk_res(tss_pkg::OUT_OK, '0, 5'(best_pos_q), best_tid_q,
                       best_pos_q != cur_q, best_wait, '0, 1'b1);
        state_d = S_IDLE;
        iss_d   = '0;
      end

      S_FIND: begin
        if (rd_pend_q) begin
          if (rec.tid == item_q.thread_id) begin
            res_vld_d = 1'b1;
            res_d = mk_res(tss_pkg::OUT_REFUSED, '0, 5'(cur_q), cur_tid_q,
                           1'b0, '0, '0, 1'b1);
            if (item_q.mode == tss_pkg::MODE_RESUME) begin
              if (rec.status == tss_pkg::ST_SUSP) begin
                wr.en          = 1'b1;
                wr.mask.status = 1'b1;
                wr.rec.status  = tss_pkg::ST_ACTIVE;
                wr_addr        = rd_pos_q;
                res_d.outcome  = tss_pkg::OUT_OK;
              end
            end else if (rec.status != tss_pkg::ST_FREE && rd_pos_q != cur_q) begin
              wr.en            = 1'b1;
              wr.mask.status   = 1'b1;
              wr.rec.status    = tss_pkg::ST_FREE;
              wr_addr          = rd_pos_q;
              res_d.outcome    = tss_pkg::OUT_OK;
              res_d.result_tid = rec.tid;
            end
            state_d = S_IDLE;
          end else if (rd_last_q) begin
            res_vld_d = 1'b1;
            res_d = mk_res(tss_pkg::OUT_REFUSED, '0, 5'(cur_q), cur_tid_q,
                           1'b0, '0, '0, 1'b1);
            state_d = S_IDLE;
          end
        end
        if (state_d != S_FIND) begin
          iss_d     = '0;
          rd_pend_d = 1'b0;
        end
      end

      S_CNT: begin
        if (rd_pend_q) begin
          cnt_d = cnt_nx;
          if (rd_last_q) begin
            iss_d     = '0;
            rd_pend_d = 1'b0;
            if (cnt_nx == '0) begin
              res_vld_d = 1'b1;
              res_d = mk_res(tss_pkg::OUT_OK, '0, 5'(cur_q), cur_tid_q,
                             1'b0, '0, '0, 1'b1);
              state_d = S_IDLE;
            end else begin
              state_d = S_LIST;
            end
          end
        end
      end

      S_LIST: begin
        if (rd_pend_q && rec.status == tss_pkg::ST_SUSP) begin
          k_d       = k_q + CNT_W'(1);
          res_vld_d = 1'b1;
          res_d = mk_res(tss_pkg::OUT_OK, rec.tid, 5'(cur_q), cur_tid_q,
                         1'b0, '0, 6'(cnt_q), (k_q + CNT_W'(1)) == cnt_q);
          // stop on the final suspended entry
          if ((k_q + CNT_W'(1)) == cnt_q) begin
            state_d   = S_IDLE;
            iss_d     = '0;
            rd_pend_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      cur_tid_q    <= '0;
      cur_qs_q     <= '0;
      next_tid_q   <= '0;
      quantum_q    <= tss_pkg::QUANTUM_RST;
      item_q       <= '0;
      iss_q        <= '0;
      rd_pend_q    <= 1'b0;
      rd_last_q    <= 1'b0;
      rd_pos_q     <= '0;
      sleepers_q   <= 1'b0;
      susp_q       <= 1'b0;
      best_found_q <= 1'b0;
      best_pos_q   <= '0;
      best_wake_q  <= '0;
      best_tid_q   <= '0;
      cnt_q        <= '0;
      k_q          <= '0;
      res_vld_q    <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      cur_tid_q    <= cur_tid_d;
      cur_qs_q     <= cur_qs_d;
      next_tid_q   <= next_tid_d;
      if (cfg_valid_i) begin
        quantum_q <= cfg_data_i;
      end
      item_q       <= item_d;
      iss_q        <= iss_d;
      rd_pend_q    <= rd_pend_d;
      rd_last_q    <= rd_last_d;
      rd_pos_q     <= rd_pos_d;
      sleepers_q   <= sleepers_d;
      susp_q       <= susp_d;
      best_found_q <= best_found_d;
      best_pos_q   <= best_pos_d;
      best_wake_q  <= best_wake_d;
      best_tid_q   <= best_tid_d;
      cnt_q        <= cnt_d;
      k_q          <= k_d;
      res_vld_q    <= res_vld_d;
      res_q        <= res_d;
    end
  end

endmodule

// File: tb/tb.sv
// Self-checking testbench of the thread slot scheduler with its own slot-table predictor.
module tb;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  tss_pkg::tss_in_t            item_i;
  logic                        result_valid_o;
  tss_pkg::tss_out_t           result_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [tss_pkg::QUANT_W-1:0] cfg_data_i;

  thread_slot_scheduler u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predicted scheduler state
  tss_pkg::slot_status_e        tbl_st    [tss_pkg::SLOTS_DEF];
  logic [tss_pkg::TID_W-1:0]    tbl_tid   [tss_pkg::SLOTS_DEF];
  logic [tss_pkg::TIME_W-1:0]   tbl_wake  [tss_pkg::SLOTS_DEF];
  logic [tss_pkg::TIME_W-1:0]   tbl_qstart[tss_pkg::SLOTS_DEF];
  int                           cur_slot;
  logic [tss_pkg::TID_W-1:0]    tid_next;
  logic [tss_pkg::QUANT_W-1:0]  quantum;

  tss_pkg::tss_out_t            due_results[$];
  int                           mismatches;
  logic [tss_pkg::TIME_W-1:0]   clock_ms;
  bit                           idle_on;

  function automatic void post_result(input logic [1:0] oc, input logic [15:0] rtid,
                                      input bit run_ok, input bit sw,
                                      input logic [15:0] wt, input logic [5:0] cnt,
                                      input bit lst);
    tss_pkg::tss_out_t r;
    r.outcome         = oc;
    r.result_tid      = rtid;
    r.running_slot    = run_ok ? cur_slot[4:0] : 5'd0;
    r.running_tid     = run_ok ? tbl_tid[cur_slot] : 16'd0;
    r.switched        = sw;
    r.wait_ms         = wt;
    r.suspended_count = cnt;
    r.last            = lst;
    due_results.push_back(r);
  endfunction

  // round robin pick; -1 only suspended left, -2 nothing left
  function automatic int pick_slot(input logic [31:0] now, output logic [31:0] qs,
                                   output logic [15:0] wt);
    bit   sleepers;
    bit   susp;
    bit   found;
    int   pos;
    int   best;
    logic [31:0] d;
    sleepers = 0;
    susp     = 0;
    found    = 0;
    best     = 0;
    qs       = now;
    wt       = '0;
    for (int i = 0; i < tss_pkg::SLOTS_DEF; i++) begin
      pos = (cur_slot + i + 1) % tss_pkg::SLOTS_DEF;
      if (tbl_st[pos] == tss_pkg::ST_DELETED) tbl_st[pos] = tss_pkg::ST_FREE;
      if (tbl_st[pos] == tss_pkg::ST_SUSP) susp = 1;
      if (tbl_st[pos] == tss_pkg::ST_SLEEP) begin
        if (now >= tbl_wake[pos]) tbl_st[pos] = tss_pkg::ST_ACTIVE;
        else sleepers = 1;
      end
      if (tbl_st[pos] == tss_pkg::ST_ACTIVE) return pos;
    end
    if (sleepers) begin
      for (int i = 0; i < tss_pkg::SLOTS_DEF; i++) begin
        if (tbl_st[i] == tss_pkg::ST_SLEEP && (!found || tbl_wake[i] < tbl_wake[best])) begin
          best  = i;
          found = 1;
        end
      end
      d  = (tbl_wake[best] > now) ? tbl_wake[best] - now : 32'd0;
      wt = (d > 32'hFFFF) ? 16'hFFFF : d[15:0];
      qs = (tbl_wake[best] > now) ? tbl_wake[best] : now;
      tbl_st[best] = tss_pkg::ST_ACTIVE;
      return best;
    end
    return susp ? -1 : -2;
  endfunction

  function automatic void reschedule(input logic [31:0] now);
    logic [31:0] qs;
    logic [15:0] wt;
    int          pos;
    pos = pick_slot(now, qs, wt);
    if (pos < 0) begin
      post_result((pos == -1) ? tss_pkg::OUT_SUSP : tss_pkg::OUT_NONE, '0, 0, 0, '0, '0, 1);
    end else begin
      post_result(tss_pkg::OUT_OK, '0, 1, 0, wt, '0, 1);
      due_results[$].switched     = (pos != cur_slot);
      cur_slot                    = pos;
      tbl_qstart[pos]             = qs;
      due_results[$].running_slot = pos[4:0];
      due_results[$].running_tid  = tbl_tid[pos];
    end
  endfunction

  function automatic int slot_of_tid(input logic [15:0] t);
    for (int i = 0; i < tss_pkg::SLOTS_DEF; i++)
      if (tbl_tid[i] == t) return i;
    return -1;
  endfunction

  function automatic void model_request(input tss_pkg::tss_in_t it);
    int          p;
    int          pos;
    int          cnt;
    int          k;
    logic [32:0] sum;
    case (it.mode)
      tss_pkg::MODE_INIT: begin
        tbl_tid[0]    = tid_next;
        tid_next      = tid_next + 1'b1;
        tbl_qstart[0] = it.now_ms;
        tbl_st[0]     = tss_pkg::ST_ACTIVE;
        tbl_wake[0]   = '0;
        post_result(tss_pkg::OUT_OK, tbl_tid[0], 1, 0, '0, '0, 1);
      end
      tss_pkg::MODE_CREATE: begin
        p = -1;
        for (int i = 0; i < tss_pkg::SLOTS_DEF && p < 0; i++) begin
          pos = (cur_slot + i + 1) % tss_pkg::SLOTS_DEF;
          if (tbl_st[pos] == tss_pkg::ST_DELETED) tbl_st[pos] = tss_pkg::ST_FREE;
          if (tbl_st[pos] == tss_pkg::ST_FREE) p = pos;
        end
        if (p < 0) begin
          post_result(tss_pkg::OUT_REFUSED, '0, 1, 0, '0, '0, 1);
        end else begin
          tbl_tid[p]    = tid_next;
          tid_next      = tid_next + 1'b1;
          tbl_qstart[p] = '0;
          tbl_st[p]     = tss_pkg::ST_ACTIVE;
          tbl_wake[p]   = '0;
          post_result(tss_pkg::OUT_OK, tbl_tid[p], 1, 0, '0, '0, 1);
        end
      end
      tss_pkg::MODE_EXIT: begin
        tbl_st[cur_slot] = tss_pkg::ST_DELETED;
        reschedule(it.now_ms);
      end
      tss_pkg::MODE_YIELD: begin
        if (it.now_ms < tbl_qstart[cur_slot] ||
            it.now_ms - tbl_qstart[cur_slot] < {16'd0, quantum})
          post_result(tss_pkg::OUT_OK, '0, 1, 0, '0, '0, 1);
        else
          reschedule(it.now_ms);
      end
      tss_pkg::MODE_SUSPEND: begin
        tbl_st[cur_slot] = tss_pkg::ST_SUSP;
        reschedule(it.now_ms);
      end
      tss_pkg::MODE_RESUME: begin
        p = slot_of_tid(it.thread_id);
        if (p < 0 || tbl_st[p] != tss_pkg::ST_SUSP) begin
          post_result(tss_pkg::OUT_REFUSED, '0, 1, 0, '0, '0, 1);
        end else begin
          tbl_st[p] = tss_pkg::ST_ACTIVE;
          post_result(tss_pkg::OUT_OK, '0, 1, 0, '0, '0, 1);
        end
      end
      tss_pkg::MODE_KILL: begin
        p = slot_of_tid(it.thread_id);
        if (p < 0 || tbl_st[p] == tss_pkg::ST_FREE || p == cur_slot) begin
          post_result(tss_pkg::OUT_REFUSED, '0, 1, 0, '0, '0, 1);
        end else begin
          tbl_st[p] = tss_pkg::ST_FREE;
          post_result(tss_pkg::OUT_OK, tbl_tid[p], 1, 0, '0, '0, 1);
        end
      end
      tss_pkg::MODE_SLEEP: begin
        tbl_st[cur_slot] = tss_pkg::ST_SLEEP;
        sum = {1'b0, it.now_ms} + it.sleep_ms;
        tbl_wake[cur_slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        reschedule(it.now_ms);
      end
      tss_pkg::MODE_LIST: begin
        cnt = 0;
        k   = 0;
        for (int i = 0; i < tss_pkg::SLOTS_DEF; i++)
          if (tbl_st[i] == tss_pkg::ST_SUSP) cnt++;
        if (cnt == 0) post_result(tss_pkg::OUT_OK, '0, 1, 0, '0, '0, 1);
        for (int i = 0; i < tss_pkg::SLOTS_DEF; i++) begin
          if (tbl_st[i] == tss_pkg::ST_SUSP) begin
            k++;
            post_result(tss_pkg::OUT_OK, tbl_tid[i], 1, 0, '0, cnt[5:0], k == cnt);
          end
        end
      end
      default: post_result(tss_pkg::OUT_REFUSED, '0, 1, 0, '0, '0, 1);
    endcase
  endfunction

  // compare every result beat with the oldest prediction
  always @(posedge clk_i) begin
    tss_pkg::tss_out_t want;
    if (rst_ni && result_valid_o) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", result_o);
      end else begin
        want = due_results.pop_front();
        if (result_o.outcome !== want.outcome || result_o.result_tid !== want.result_tid ||
            result_o.running_slot !== want.running_slot ||
            result_o.running_tid !== want.running_tid ||
            result_o.switched !== want.switched || result_o.wait_ms !== want.wait_ms ||
            result_o.suspended_count !== want.suspended_count ||
            result_o.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, result_o);
        end
      end
    end
  end

  task automatic send_item(input tss_pkg::tss_in_t it);
    if (idle_on && $urandom_range(99) < 23) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    model_request(it);
  endtask

  task automatic req(input logic [3:0] m, input logic [15:0] t, input logic [15:0] s,
                     input logic [31:0] now);
    tss_pkg::tss_in_t it;
    it.mode      = m;
    it.thread_id = t;
    it.sleep_ms  = s;
    it.now_ms    = now;
    send_item(it);
  endtask

  // hold start low until every predicted beat is back, then let the block settle
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_quantum(input logic [15:0] q);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= q;
    do @(posedge clk_i); while (!cfg_ready_o);
    quantum = q;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    req(tss_pkg::MODE_LIST, 0, 0, 0);
    req(tss_pkg::MODE_YIELD, 0, 0, 0);
    req(tss_pkg::MODE_YIELD, 0, 0, 1000);
    req(tss_pkg::MODE_EXIT, 0, 0, 1000);
    req(tss_pkg::MODE_INIT, 0, 0, 0);
    repeat (3) req(tss_pkg::MODE_CREATE, 16'hFFFF, 16'hFFFF, 0);
    req(tss_pkg::MODE_YIELD, 0, 0, 100);
    req(tss_pkg::MODE_YIELD, 0, 0, 300);
    req(tss_pkg::MODE_SUSPEND, 0, 0, 310);
    req(tss_pkg::MODE_LIST, 0, 0, 320);
    req(tss_pkg::MODE_RESUME, 1, 0, 330);
    req(tss_pkg::MODE_RESUME, 1, 0, 330);
    req(tss_pkg::MODE_RESUME, 999, 0, 330);
    req(tss_pkg::MODE_KILL, 2, 0, 340);
    req(tss_pkg::MODE_KILL, 3, 0, 340);
    req(tss_pkg::MODE_KILL, 777, 0, 340);
    req(tss_pkg::MODE_SLEEP, 0, 16'hFFFF, 400);
    req(tss_pkg::MODE_EXIT, 0, 0, 500);
    req(tss_pkg::MODE_SLEEP, 0, 16'hFFFF, 32'hFFFF_FFF0);
    req(tss_pkg::MODE_SUSPEND, 0, 0, 32'hFFFF_FFF0);
    req(4'd9, 0, 0, 32'hFFFF_FFF0);
    req(4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    req(tss_pkg::MODE_EXIT, 0, 0, 32'hFFFF_FFFF);
  endtask

  task automatic test_table_full();
    req(tss_pkg::MODE_INIT, 0, 0, 0);
    repeat (tss_pkg::SLOTS_DEF) req(tss_pkg::MODE_CREATE, 0, 0, 10);
    req(tss_pkg::MODE_SUSPEND, 0, 0, 20);
    req(tss_pkg::MODE_LIST, 0, 0, 20);
  endtask

  task automatic test_random(input int n);
    tss_pkg::tss_in_t it;
    int               r;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(99);
      it.mode = (r < 3)  ? tss_pkg::MODE_INIT :
                (r < 23) ? tss_pkg::MODE_CREATE :
                (r < 31) ? tss_pkg::MODE_EXIT :
                (r < 46) ? tss_pkg::MODE_YIELD :
                (r < 56) ? tss_pkg::MODE_SUSPEND :
                (r < 68) ? tss_pkg::MODE_RESUME :
                (r < 78) ? tss_pkg::MODE_KILL :
                (r < 90) ? tss_pkg::MODE_SLEEP :
                (r < 96) ? tss_pkg::MODE_LIST : 4'($urandom_range(9, 15));
      it.thread_id = ($urandom_range(99) < 75) ?
                     tbl_tid[$urandom_range(tss_pkg::SLOTS_DEF - 1)] : 16'($urandom());
      it.sleep_ms  = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 1000))
                                              : 16'($urandom());
      r = $urandom_range(99);
      if (r < 80) clock_ms = clock_ms + $urandom_range(0, 400);
      else if (r < 90) clock_ms = clock_ms + $urandom_range(0, 100000);
      else if (r < 95) clock_ms = $urandom();
      it.now_ms = clock_ms;
      send_item(it);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    mismatches  = 0;
    clock_ms    = '0;
    idle_on     = 1'b1;
    quantum     = tss_pkg::QUANTUM_RST;
    cur_slot    = 0;
    tid_next    = '0;
    for (int i = 0; i < tss_pkg::SLOTS_DEF; i++) begin
      tbl_st[i]     = tss_pkg::ST_FREE;
      tbl_tid[i]    = '0;
      tbl_wake[i]   = '0;
      tbl_qstart[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_table_full();
    write_quantum(16'd0);
    test_random(60);
    write_quantum(16'hFFFF);
    idle_on = 1'b0;
    test_random(60);
    idle_on = 1'b1;
    write_quantum(16'($urandom_range(1, 600)));
    test_random(60);
    write_quantum(tss_pkg::QUANTUM_RST);
    test_random(60);
    drain();

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
